### hw/rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge, disabled while reset is asserted.
`define FTFD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("deframer assertion failed");
// Check prop at every rising edge, reset included.
`define FTFD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("deframer assertion failed");
`else
`define FTFD_ASSERT(lbl, clk, rstn, prop)
`define FTFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/ftfd_pkg.sv
// Package for the force/torque frame deframer: constants, stage types and
// the float to Q31.16 conversion functions. No dependencies.
package ftfd_pkg;

    localparam int FRAME_BYTES = 28;
    localparam int FILL_W      = $clog2(FRAME_BYTES);
    localparam int NUM_AXES    = 6;
    localparam int FIRST_VALUE = 2;
    localparam int Q_W         = 48;
    localparam int SCALE_W     = 16;
    localparam int MANT_W      = 24;
    localparam int PROD_W      = MANT_W + SCALE_W;
    localparam int EXP_BIAS_Q  = 134;

    localparam logic [7:0]         CH_CR        = 8'h0d;
    localparam logic [7:0]         CH_LF        = 8'h0a;
    localparam logic [7:0]         EXP_SPECIAL  = 8'hff;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd1000;
    localparam logic [Q_W-1:0]     Q_MAX        = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0]     Q_MIN        = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic [7:0] byte_t;

    // Raw little-endian words of one complete frame.
    typedef struct packed {
        logic [NUM_AXES-1:0][31:0] words;
    } frame_t;

    // One axis after the mantissa multiply.
    typedef struct packed {
        logic              neg;
        logic              special;
        logic signed [8:0] shift;
        logic [PROD_W-1:0] prod;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_AXES-1:0] lanes;
    } scaled_t;

    typedef struct packed {
        logic [Q_W-1:0] value;
        logic           sat;
    } fix_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][Q_W-1:0] values;
        logic                         sat;
    } result_t;

    // Split the float and multiply its mantissa by the scale factor.
    function automatic lane_t lane_prep(input logic [31:0] bits,
                                        input logic [SCALE_W-1:0] scale);
        lane_t            l;
        logic [7:0]       e;
        logic [7:0]       e_eff;
        logic [MANT_W-1:0] m;
        e       = bits[30:23];
        e_eff   = (e == 8'd0) ? 8'd1 : e;
        m       = {(e != 8'd0), bits[22:0]};
        l.neg     = bits[31];
        l.special = (e == EXP_SPECIAL);
        l.shift   = $signed({1'b0, e_eff}) - 9'sd134;
        l.prod    = {{SCALE_W{1'b0}}, m} * {{MANT_W{1'b0}}, scale};
        return l;
    endfunction

    // Align the product to Q31.16, floor toward minus infinity, saturate.
    function automatic fix_t lane_fix(input lane_t l);
        fix_t                  f;
        logic [PROD_W+Q_W-1:0] up;
        logic [2*PROD_W-1:0]   dn;
        logic [8:0]            r;
        logic [5:0]            rc;
        logic [PROD_W-1:0]     q;
        logic                  inc;
        f.sat   = 1'b0;
        f.value = '0;
        up      = '0;
        dn      = '0;
        r       = 9'(-l.shift);
        rc      = (r > 9'(PROD_W)) ? 6'(PROD_W) : r[5:0];
        q       = '0;
        inc     = 1'b0;
        if (l.special) begin
            f.sat   = 1'b1;
            f.value = l.neg ? Q_MIN : Q_MAX;
        end
        else if (l.prod == '0) begin
            f.value = '0;
        end
        else if (!l.shift[8]) begin
            if (l.shift > 9'sd47) begin
                f.sat   = 1'b1;
                f.value = l.neg ? Q_MIN : Q_MAX;
            end
            else begin
                up = {{Q_W{1'b0}}, l.prod} << l.shift[5:0];
                if (up[PROD_W+Q_W-1:Q_W-1] == '0) begin
                    f.value = l.neg ? (Q_W'(0) - up[Q_W-1:0]) : up[Q_W-1:0];
                end
                else if (l.neg && up == {{PROD_W{1'b0}}, Q_MIN}) begin
                    f.value = Q_MIN;
                end
                else begin
                    f.sat   = 1'b1;
                    f.value = l.neg ? Q_MIN : Q_MAX;
                end
            end
        end
        else begin
            dn  = {l.prod, {PROD_W{1'b0}}} >> rc;
            q   = dn[2*PROD_W-1:PROD_W];
            inc = |dn[PROD_W-1:0];
            if (l.neg) begin
                f.value = Q_W'(0) - (Q_W'(q) + Q_W'(inc));
            end
            else begin
                f.value = Q_W'(q);
            end
        end
        return f;
    endfunction

endpackage

### hw/rtl/ftfd_window.sv
// Byte window of the deframer: shift line, fill count, frame check and resync.
// Depends on ftfd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ftfd_window
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ftfd_pkg::byte_t     rx_byte,
    output logic                frm_valid,
    input  logic                frm_ready,
    output ftfd_pkg::frame_t    frm
);

    ftfd_pkg::byte_t               sh_reg [ftfd_pkg::FRAME_BYTES];
    ftfd_pkg::byte_t               win    [ftfd_pkg::FRAME_BYTES];
    logic [ftfd_pkg::FILL_W-1:0]   fill_reg;
    logic [ftfd_pkg::FILL_W-1:0]   fill_next;
    logic [ftfd_pkg::FILL_W:0]     fill_inc;
    logic                          frm_valid_reg;
    logic                          frm_valid_next;
    ftfd_pkg::frame_t              frm_reg;
    ftfd_pkg::frame_t              frm_next;
    logic                          in_fire;
    logic                          full;
    logic                          frame_hit;
    logic                          pair_found;
    logic [ftfd_pkg::FILL_W-1:0]   pair_fill;

    assign in_ready = !frm_valid_reg || frm_ready;
    assign in_fire  = in_valid && in_ready;

    // Window as it stands once the incoming byte is appended to a full line.
    always_comb
    begin
        for (int i = 0; i < ftfd_pkg::FRAME_BYTES - 1; i++) begin
            win[i] = sh_reg[i+1];
        end
        win[ftfd_pkg::FRAME_BYTES-1] = rx_byte;
    end

    always_comb
    begin
        frm_next = '0;
        for (int k = 0; k < ftfd_pkg::NUM_AXES; k++) begin
            for (int j = 0; j < 4; j++) begin
                if (ftfd_pkg::FIRST_VALUE + 4*k + j < ftfd_pkg::FRAME_BYTES) begin
                    frm_next.words[k][8*j +: 8] = win[ftfd_pkg::FIRST_VALUE + 4*k + j];
                end
            end
        end
    end

    // Lowest CR-LF pair wins: scan from the top so lower hits overwrite.
    always_comb
    begin
        pair_found = 1'b0;
        pair_fill  = '0;
        for (int p = ftfd_pkg::FRAME_BYTES - 2; p >= 0; p--) begin
            if (win[p] == ftfd_pkg::CH_CR && win[p+1] == ftfd_pkg::CH_LF) begin
                pair_found = 1'b1;
                pair_fill  = ftfd_pkg::FILL_W'(ftfd_pkg::FRAME_BYTES - 2 - p);
            end
        end
    end

    assign fill_inc  = {1'b0, fill_reg} + 1'b1;
    assign full      = (fill_inc == (ftfd_pkg::FILL_W+1)'(ftfd_pkg::FRAME_BYTES));
    assign frame_hit = full
        && win[ftfd_pkg::FRAME_BYTES-2] == ftfd_pkg::CH_CR
        && win[ftfd_pkg::FRAME_BYTES-1] == ftfd_pkg::CH_LF;

    always_comb
    begin
        priority if (!full) begin
            fill_next = fill_inc[ftfd_pkg::FILL_W-1:0];
        end
        else if (frame_hit) begin
            fill_next = '0;
        end
        else if (win[0] == ftfd_pkg::CH_LF) begin
            fill_next = ftfd_pkg::FILL_W'(ftfd_pkg::FRAME_BYTES - 1);
        end
        else if (pair_found) begin
            fill_next = pair_fill;
        end
        else begin
            // no pair: keep only the newest byte
            fill_next = ftfd_pkg::FILL_W'(1);
        end
    end

    always_comb
    begin
        frm_valid_next = frm_valid_reg;
        if (frm_valid_reg && frm_ready) begin
            frm_valid_next = 1'b0;
        end
        if (in_fire && frame_hit) begin
            frm_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg      <= '0;
            frm_valid_reg <= 1'b0;
        end
        else begin
            frm_valid_reg <= frm_valid_next;
            if (in_fire) begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            for (int i = 0; i < ftfd_pkg::FRAME_BYTES - 1; i++) begin
                sh_reg[i] <= sh_reg[i+1];
            end
            sh_reg[ftfd_pkg::FRAME_BYTES-1] <= rx_byte;
            if (frame_hit) begin
                frm_reg <= frm_next;
            end
        end
    end

    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    `FTFD_ASSERT(a_fill_bound, clk, rst_n,
        fill_reg < ftfd_pkg::FILL_W'(ftfd_pkg::FRAME_BYTES))
    `FTFD_ASSERT(a_frame_empties, clk, rst_n,
        (in_fire && frame_hit) |=> (fill_reg == '0 && frm_valid_reg))
    `FTFD_ASSERT(a_frame_holds, clk, rst_n,
        (frm_valid_reg && !frm_ready) |=> (frm_valid_reg && $stable(frm_reg)))

endmodule

### hw/rtl/ftfd_scale.sv
// Multiply stage: splits the six floats and scales their mantissas.
// Depends on ftfd_pkg.
module ftfd_scale
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ftfd_pkg::SCALE_W-1:0]  scale_factor,
    input  logic                          frm_valid,
    output logic                          frm_ready,
    input  ftfd_pkg::frame_t              frm,
    output logic                          scl_valid,
    input  logic                          scl_ready,
    output ftfd_pkg::scaled_t             scl
);

    logic              scl_valid_reg;
    ftfd_pkg::scaled_t scl_reg;
    ftfd_pkg::scaled_t scl_next;

    assign frm_ready = !scl_valid_reg || scl_ready;

    always_comb
    begin
        for (int k = 0; k < ftfd_pkg::NUM_AXES; k++) begin
            scl_next.lanes[k] = ftfd_pkg::lane_prep(frm.words[k], scale_factor);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scl_valid_reg <= 1'b0;
        end
        else if (frm_ready) begin
            scl_valid_reg <= frm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frm_ready && frm_valid) begin
            scl_reg <= scl_next;
        end
    end

    assign scl_valid = scl_valid_reg;
    assign scl       = scl_reg;

endmodule

### hw/rtl/ftfd_fixconv.sv
// Output stage: shifts each product to Q31.16, saturates, holds the result.
// Depends on ftfd_pkg.
module ftfd_fixconv
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               scl_valid,
    output logic               scl_ready,
    input  ftfd_pkg::scaled_t  scl,
    output logic               out_valid,
    input  logic               out_ready,
    output ftfd_pkg::result_t  res
);

    logic              out_valid_reg;
    ftfd_pkg::result_t res_reg;
    ftfd_pkg::result_t res_next;
    ftfd_pkg::fix_t    fx [ftfd_pkg::NUM_AXES];

    assign scl_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        res_next.sat = 1'b0;
        for (int k = 0; k < ftfd_pkg::NUM_AXES; k++) begin
            fx[k]              = ftfd_pkg::lane_fix(scl.lanes[k]);
            res_next.values[k] = fx[k].value;
            res_next.sat       = res_next.sat | fx[k].sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (scl_ready) begin
            out_valid_reg <= scl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scl_ready && scl_valid) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

### hw/rtl/force_torque_frame_deframer_unit.sv
// Force/torque frame deframer: takes one byte per transaction, finds CR-LF
// framed 28-byte records and delivers six scaled Q31.16 axis values.
// Pipeline: the edge that accepts the frame's final LF byte loads the frame register;
// the multiply register and then the output register follow in order.
// Throughput: one byte per cycle while in_ready is high; every stage advances while the next is free.
// Reset: window empty, pipeline empty, scale_factor back to 1000.
module force_torque_frame_deframer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ftfd_pkg::SCALE_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ftfd_pkg::Q_W-1:0] force_x,
    output logic signed [ftfd_pkg::Q_W-1:0] force_y,
    output logic signed [ftfd_pkg::Q_W-1:0] force_z,
    output logic signed [ftfd_pkg::Q_W-1:0] torque_x,
    output logic signed [ftfd_pkg::Q_W-1:0] torque_y,
    output logic signed [ftfd_pkg::Q_W-1:0] torque_z,
    output logic                          saturated
);

    logic [ftfd_pkg::SCALE_W-1:0] scale_reg;
    logic                         frm_valid;
    logic                         frm_ready;
    ftfd_pkg::frame_t             frm;
    logic                         scl_valid;
    logic                         scl_ready;
    ftfd_pkg::scaled_t            scl;
    ftfd_pkg::result_t            res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scale_reg <= ftfd_pkg::SCALE_RESET;
        end
        else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    ftfd_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm)
    );

    ftfd_scale u_scale
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale_factor (scale_reg),
        .frm_valid    (frm_valid),
        .frm_ready    (frm_ready),
        .frm          (frm),
        .scl_valid    (scl_valid),
        .scl_ready    (scl_ready),
        .scl          (scl)
    );

    ftfd_fixconv u_fixconv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .scl_valid (scl_valid),
        .scl_ready (scl_ready),
        .scl       (scl),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign force_x   = res.values[0];
    assign force_y   = res.values[1];
    assign force_z   = res.values[2];
    assign torque_x  = res.values[3];
    assign torque_y  = res.values[4];
    assign torque_z  = res.values[5];
    assign saturated = res.sat;

endmodule

### tb/sv/tb_force_torque_frame_deframer_unit.sv
`timescale 1ns / 1ps
// Testbench for force_torque_frame_deframer_unit: streams serial bytes, tracks the
// deframing window in its own predictor and checks every decoded six-axis sample.
// Depends on ftfd_pkg and the deframer RTL only.
module tb_force_torque_frame_deframer_unit;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 650;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [ftfd_pkg::NUM_AXES-1:0][ftfd_pkg::Q_W-1:0] axes;
        logic                                             sat;
    } ft_sample_t;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [ftfd_pkg::SCALE_W-1:0]    cfg_wr_data = '0;
    logic                            in_valid    = 1'b0;
    logic                            in_ready;
    logic [7:0]                      rx_byte     = '0;
    logic                            out_valid;
    logic                            out_ready   = 1'b0;
    logic signed [ftfd_pkg::Q_W-1:0] force_x;
    logic signed [ftfd_pkg::Q_W-1:0] force_y;
    logic signed [ftfd_pkg::Q_W-1:0] force_z;
    logic signed [ftfd_pkg::Q_W-1:0] torque_x;
    logic signed [ftfd_pkg::Q_W-1:0] torque_y;
    logic signed [ftfd_pkg::Q_W-1:0] torque_z;
    logic                            saturated;

    // Predictor state: byte window, fill level and scale factor.
    ftfd_pkg::byte_t              ft_window [ftfd_pkg::FRAME_BYTES];
    int                           ft_fill  = 0;
    logic [ftfd_pkg::SCALE_W-1:0] ft_scale = ftfd_pkg::SCALE_RESET;

    ftfd_pkg::byte_t rx_pending [$];
    ft_sample_t      sample_q [$];
    logic [31:0]     axis_words [ftfd_pkg::NUM_AXES];
    int              mismatches    = 0;
    int              bytes_queued  = 0;
    bit              steady_send   = 1'b0;
    int              hold_req      = 0;

    force_torque_frame_deframer_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .force_x     (force_x),
        .force_y     (force_y),
        .force_z     (force_z),
        .torque_x    (torque_x),
        .torque_y    (torque_y),
        .torque_z    (torque_z),
        .saturated   (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scale one IEEE single exactly and floor it into Q31.16, saturating at 48 bits.
    function automatic logic [ftfd_pkg::Q_W-1:0] axis_to_fixed(input logic [31:0] bits,
                                                               inout logic sat);
        logic                     neg;
        logic [7:0]               e;
        logic [63:0]              p;
        logic [63:0]              mag;
        logic [63:0]              q;
        logic [63:0]              rem;
        logic [ftfd_pkg::Q_W-1:0] res;
        int                       s;
        int                       r;
        neg = bits[31];
        e   = bits[30:23];
        p   = {40'd0, (e != 8'd0), bits[22:0]} * {48'd0, ft_scale};
        s   = ((e == 8'd0) ? 1 : int'(e)) - ftfd_pkg::EXP_BIAS_Q;
        res = '0;
        if (e == ftfd_pkg::EXP_SPECIAL)
        begin
            sat = 1'b1;
            res = neg ? ftfd_pkg::Q_MIN : ftfd_pkg::Q_MAX;
        end
        else if (p == 64'd0)
        begin
            res = '0;
        end
        else if (s >= 0)
        begin
            if (s <= ftfd_pkg::Q_W - 1 && (p >> (ftfd_pkg::Q_W - 1 - s)) == 64'd0)
            begin
                mag = p << s;
                res = neg ? ftfd_pkg::Q_W'(64'd0 - mag) : mag[ftfd_pkg::Q_W-1:0];
            end
            else if (neg && s <= ftfd_pkg::Q_W - 1
                     && p == (64'd1 << (ftfd_pkg::Q_W - 1 - s)))
            begin
                res = ftfd_pkg::Q_MIN;
            end
            else
            begin
                sat = 1'b1;
                res = neg ? ftfd_pkg::Q_MIN : ftfd_pkg::Q_MAX;
            end
        end
        else
        begin
            r = -s;
            if (r >= 64)
            begin
                q   = 64'd0;
                rem = p;
            end
            else
            begin
                q   = p >> r;
                rem = p & ((64'd1 << r) - 64'd1);
            end
            // floor: negative values with dropped bits move one step down
            if (neg)
                res = ftfd_pkg::Q_W'(64'd0 - (q + 64'(rem != 64'd0)));
            else
                res = q[ftfd_pkg::Q_W-1:0];
        end
        return res;
    endfunction

    function automatic void drop_front(input int n);
        if (n >= ft_fill)
        begin
            ft_fill = 0;
        end
        else
        begin
            for (int i = 0; i < ft_fill - n; i++)
                ft_window[i] = ft_window[i + n];
            ft_fill -= n;
        end
    endfunction

    // Advance the window by one accepted byte; queue a sample when a frame closes.
    function automatic void absorb_byte(input ftfd_pkg::byte_t b);
        ft_sample_t  smp;
        logic [31:0] w;
        int          cut;
        int          base;
        smp = '0;
        cut = -1;
        ft_window[ft_fill] = b;
        ft_fill++;
        if (ft_fill < ftfd_pkg::FRAME_BYTES)
            return;
        if (ft_window[ftfd_pkg::FRAME_BYTES-2] == ftfd_pkg::CH_CR
            && ft_window[ftfd_pkg::FRAME_BYTES-1] == ftfd_pkg::CH_LF)
        begin
            for (int k = 0; k < ftfd_pkg::NUM_AXES; k++)
            begin
                base = ftfd_pkg::FIRST_VALUE + 4 * k;
                w = {ft_window[base+3], ft_window[base+2],
                     ft_window[base+1], ft_window[base]};
                smp.axes[k] = axis_to_fixed(w, smp.sat);
            end
            sample_q.insert(sample_q.size(), smp);
            ft_fill = 0;
        end
        else if (ft_window[0] == ftfd_pkg::CH_LF)
        begin
            drop_front(1);
        end
        else
        begin
            // resync through the first CR-LF pair, else keep only the newest byte
            for (int i = ftfd_pkg::FRAME_BYTES - 2; i >= 0; i--)
                if (ft_window[i] == ftfd_pkg::CH_CR && ft_window[i+1] == ftfd_pkg::CH_LF)
                    cut = i;
            drop_front(cut >= 0 ? cut + 2 : ftfd_pkg::FRAME_BYTES - 1);
        end
    endfunction

    function automatic logic [31:0] pick_float();
        logic        s;
        logic [7:0]  e;
        logic [22:0] m;
        s = 1'($urandom);
        e = 8'($urandom);
        m = 23'($urandom);
        case ($urandom_range(0, 9))
            0: ;
            1:
            begin
                e = 8'd0;
                m = '0;
            end
            2: e = 8'd0;
            3:
            begin
                e = ftfd_pkg::EXP_SPECIAL;
                m = '0;
            end
            4:
            begin
                e = ftfd_pkg::EXP_SPECIAL;
                m[$urandom_range(0, 22)] = 1'b1;
            end
            5, 6: e = 8'($urandom_range(110, 140));
            7: e = 8'($urandom_range(138, 165));
            8: e = 8'($urandom_range(1, 109));
            default:
            begin
                e = 8'($urandom_range(126, 150));
                m[15:0] = '0;
            end
        endcase
        return {s, e, m};
    endfunction

    function automatic void send_byte(input ftfd_pkg::byte_t b);
        rx_pending.insert(rx_pending.size(), b);
        bytes_queued++;
    endfunction

    // Header, the six words in axis_words, then a CR-LF trailer or a broken one.
    function automatic void send_frame(input bit good_tail);
        ftfd_pkg::byte_t b;
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        for (int k = 0; k < ftfd_pkg::NUM_AXES; k++)
            for (int j = 0; j < 4; j++)
                send_byte(axis_words[k][8*j +: 8]);
        if (good_tail)
        begin
            send_byte(ftfd_pkg::CH_CR);
            send_byte(ftfd_pkg::CH_LF);
        end
        else
        begin
            b = 8'($urandom);
            case ($urandom_range(0, 2))
                0:
                begin
                    send_byte(ftfd_pkg::CH_CR);
                    send_byte(b == ftfd_pkg::CH_LF ? 8'h00 : b);
                end
                1:
                begin
                    send_byte(ftfd_pkg::CH_LF);
                    send_byte(ftfd_pkg::CH_CR);
                end
                default:
                begin
                    send_byte(b);
                    send_byte(8'($urandom));
                end
            endcase
        end
    endfunction

    function automatic void send_random_frame(input bit good_tail);
        foreach (axis_words[k])
            axis_words[k] = pick_float();
        send_frame(good_tail);
    endfunction

    function automatic void send_random_chunk();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 78)
        begin
            send_random_frame(1'b1);
        end
        else if (pick < 86)
        begin
            send_random_frame(1'b0);
        end
        else if (pick < 93)
        begin
            // truncated frame with a proper trailer
            n = $urandom_range(1, 25);
            repeat (n) send_byte(8'($urandom));
            send_byte(ftfd_pkg::CH_CR);
            send_byte(ftfd_pkg::CH_LF);
        end
        else
        begin
            n = $urandom_range(1, 10);
            if ($urandom_range(0, 1) == 0)
                send_byte(ftfd_pkg::CH_LF);
            repeat (n) send_byte(8'($urandom));
        end
    endfunction

    task automatic wait_idle();
        while (rx_pending.size() != 0 || in_valid || sample_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_scale(input logic [ftfd_pkg::SCALE_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ft_scale = value;
        @(negedge clk);
    endtask

    function automatic void check_field(input string name,
                                        input logic [ftfd_pkg::Q_W-1:0] got,
                                        input logic [ftfd_pkg::Q_W-1:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d",
                         $realtime, name, $signed(want), $signed(got));
        end
    endfunction

    // Byte driver: bursts with random gaps, gaps skipped while steady_send is set.
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_byte(rx_byte);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 && !steady_send)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (rx_pending.size() != 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_pending[0];
                    rx_pending.delete(0);
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                                  : $urandom_range(0, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: one long hold on request, otherwise rotating stall patterns.
    int hold_taken = 0;
    int hold_left  = 0;
    int mode_left  = 0;
    int stall_mode = 0;
    int tick       = 0;
    always @(posedge clk)
    begin
        tick++;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_taken != hold_req)
        begin
            hold_taken = hold_req;
            hold_left  = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (tick % 7) < 4;
            endcase
        end
    end

    // Compare each delivered sample with the oldest prediction.
    always @(posedge clk)
    begin
        ft_sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sample_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result transaction with no sample expected", $realtime);
            end
            else
            begin
                want = sample_q[0];
                sample_q.delete(0);
                check_field("force_x", force_x, want.axes[0]);
                check_field("force_y", force_y, want.axes[1]);
                check_field("force_z", force_z, want.axes[2]);
                check_field("torque_x", torque_x, want.axes[3]);
                check_field("torque_y", torque_y, want.axes[4]);
                check_field("torque_z", torque_z, want.axes[5]);
                check_field("saturated", ftfd_pkg::Q_W'(saturated),
                            ftfd_pkg::Q_W'(want.sat));
            end
        end
    end

    // Watchdog on cycles without any transaction.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [ftfd_pkg::SCALE_W-1:0] next_scale;
        int                           phase;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset scale: signed zeros, largest finite values, infinities.
        axis_words = '{32'h0000_0000, 32'h8000_0000, 32'h7f7f_ffff,
                       32'hff7f_ffff, 32'h7f80_0000, 32'hff80_0000};
        send_frame(1'b1);
        // NaNs of both signs, tiny denormals, unit values.
        axis_words = '{32'h7fc0_0000, 32'hffc0_0001, 32'h0000_0001,
                       32'h8000_0001, 32'h3f80_0000, 32'hbf80_0001};
        send_frame(1'b1);
        // Full window led by LF, then a CR-LF pair mid-window; realign after each.
        send_byte(ftfd_pkg::CH_LF);
        repeat (27) send_byte(8'h55);
        send_random_frame(1'b1);
        send_random_frame(1'b1);
        repeat (10) send_byte(8'h33);
        send_byte(ftfd_pkg::CH_CR);
        send_byte(ftfd_pkg::CH_LF);
        repeat (16) send_byte(8'h44);
        send_random_frame(1'b1);
        send_random_frame(1'b1);
        wait_idle();

        // Unit scale: exactly -2^47 is representable, +2^47 saturates.
        write_scale(16'd1);
        axis_words = '{32'hcf00_0000, 32'h4f00_0000, 32'h4eff_ffff,
                       32'hcf00_0001, 32'h3f80_0000, 32'h0000_0000};
        send_frame(1'b1);
        wait_idle();

        write_scale(16'd32768);
        axis_words = '{32'hc780_0000, 32'h4780_0000, 32'hbf80_0000,
                       32'h3fc0_0000, 32'hc77f_ffff, 32'h4700_0000};
        send_frame(1'b1);
        wait_idle();

        write_scale(16'hffff);
        axis_words = '{32'h3f80_0000, 32'hbf80_0000, 32'h7f7f_ffff,
                       32'h0080_0000, 32'h8080_0000, 32'h477f_ff00};
        send_frame(1'b1);
        wait_idle();

        // Zero scale flattens finite values; specials still saturate.
        write_scale(16'd0);
        axis_words = '{32'h3f80_0000, 32'hff80_0000, 32'h7fc0_0000,
                       32'h8000_0001, 32'h0000_0000, 32'h7f7f_ffff};
        send_frame(1'b1);
        wait_idle();

        // Back-pressure: hold the receiver while frames stream back to back.
        write_scale(16'($urandom_range(1, 65535)));
        repeat (12) send_random_frame(1'b1);
        steady_send = 1'b1;
        hold_req++;
        wait_idle();
        steady_send = 1'b0;

        bytes_queued = 0;
        phase        = 0;
        while (bytes_queued < RANDOM_BYTES)
        begin
            case (phase % 5)
                0: next_scale = 16'd1;
                1: next_scale = 16'hffff;
                2: next_scale = ftfd_pkg::SCALE_RESET;
                default: next_scale = 16'($urandom_range(1, 65535));
            endcase
            write_scale(next_scale);
            repeat ($urandom_range(4, 9)) send_random_chunk();
            wait_idle();
            phase++;
        end

        if (mismatches == 0 && sample_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
